### src/bgsub_pkg.sv
// Shared types and constants for the running-average background subtraction block.
// No dependencies; imported by bgsub_pe and background_subtraction_pixel.
`timescale 1ns / 1ps
`default_nettype none

package bgsub_pkg;

  localparam int IDX_W   = 19;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int DIFF_W  = 17;
  localparam int WGT_W   = 9;
  localparam int ACT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam int MAX_PIXELS_DEF = 524288;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LEARN   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEGMENT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR     = 2'd2;

  // luma weights over 256
  localparam logic signed [DIFF_W-1:0] W_RED   = 17'sd77;
  localparam logic signed [DIFF_W-1:0] W_GREEN = 17'sd150;
  localparam logic signed [DIFF_W-1:0] W_BLUE  = 17'sd29;

  localparam logic signed [DIFF_W-1:0] THRESHOLD_RST = 17'sd2560;
  localparam logic [WGT_W-1:0]         WEIGHT_MAX    = 9'd256;

  typedef struct packed {
    logic signed [DIFF_W-1:0] threshold;
    logic [WGT_W-1:0]         blend_weight;
    logic                     color_mode;
  } cfg_t;

endpackage

`default_nettype wire

### src/background_subtraction_pixel.sv
// Top level of the running-average background subtraction block.
// Depends on bgsub_pkg and bgsub_pe; holds the background store memory.
`timescale 1ns / 1ps
`default_nettype none

// One pixel word can be taken every clock. Each word reads its background entry from a
// synchronous memory (one read, one write per cycle) at the edge that takes it; once the
// word advances from stage 1, the difference, decision and write-back complete and a
// segment result lands in the output register. The input stalls only while a segment word
// waits behind a mask word that the result side has not taken. Back-to-back words at the
// same position see each other through a forwarding register that holds the most recent
// store write. The store is MAX_PIXELS entries of 24 bits and is not cleared at reset:
// load or learn a position before segmenting it. Load and learn produce no result; segment
// produces one. Registers are to be written through the cfg port only while no word is in
// flight; the block itself does not enforce this.
module background_subtraction_pixel #(
  parameter int MAX_PIXELS = bgsub_pkg::MAX_PIXELS_DEF
) (
  input  wire  logic                                   clk,
  input  wire  logic                                   rst_n,
  input  wire  logic                                   in_valid,
  output logic                                         in_ready,
  input  wire  logic [bgsub_pkg::ACT_W-1:0]            in_action,
  input  wire  logic [bgsub_pkg::IDX_W-1:0]            in_pixel_index,
  input  wire  logic [bgsub_pkg::CH_W-1:0]             in_chan_a,
  input  wire  logic [bgsub_pkg::CH_W-1:0]             in_chan_b,
  input  wire  logic [bgsub_pkg::CH_W-1:0]             in_chan_c,
  output logic                                         out_valid,
  input  wire  logic                                   out_ready,
  output logic [bgsub_pkg::IDX_W-1:0]                  out_index,
  output logic                                         out_is_foreground,
  output logic signed [bgsub_pkg::DIFF_W-1:0]          out_luma_difference,
  input  wire  logic                                   cfg_valid,
  output logic                                         cfg_ready,
  input  wire  logic [bgsub_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  logic [bgsub_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import bgsub_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic [PIX_W-1:0] bg_mem [MAX_PIXELS];

  cfg_t cfg_r;

  // stage 1: word waiting on its memory read
  logic                     s1_valid_r;
  logic [ACT_W-1:0]         s1_action_r;
  logic [IDX_W-1:0]         s1_index_r;
  logic [PIX_W-1:0]         s1_pix_r;
  logic                     s1_inside_r;
  logic [PIX_W-1:0]         rd_data_r;

  // last store write, for forwarding
  logic                     fwd_valid_r;
  logic [AW-1:0]            fwd_addr_r;
  logic [PIX_W-1:0]         fwd_data_r;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_index_r;
  logic                     out_fg_r;
  logic signed [DIFF_W-1:0] out_diff_r;

  logic                     in_fire;
  logic                     s1_has_result;
  logic                     s1_adv;
  logic [AW-1:0]            in_addr;
  logic [AW-1:0]            s1_addr;
  logic                     in_inside;
  logic [PIX_W-1:0]         old_raw;
  logic [PIX_W-1:0]         old;
  logic                     pe_wr_en;
  logic [PIX_W-1:0]         pe_wr_data;
  logic                     pe_fg;
  logic signed [DIFF_W-1:0] pe_diff;
  logic                     wr_en;

  assign in_addr   = AW'(in_pixel_index);
  assign s1_addr   = AW'(s1_index_r);
  assign in_inside = (32'(in_pixel_index) < 32'(MAX_PIXELS));

  assign s1_has_result = (s1_action_r == ACT_SEGMENT);
  assign s1_adv   = s1_valid_r && (!s1_has_result || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // newest write wins over the registered read word
  assign old_raw = (fwd_valid_r && fwd_addr_r == s1_addr) ? fwd_data_r : rd_data_r;
  assign old     = s1_inside_r ? old_raw : '0;

  bgsub_pe u_pe (
    .cfg      (cfg_r),
    .action   (s1_action_r),
    .in_range (s1_inside_r),
    .pix      (s1_pix_r),
    .old      (old),
    .wr_en    (pe_wr_en),
    .wr_data  (pe_wr_data),
    .is_fg    (pe_fg),
    .diff     (pe_diff)
  );

  assign wr_en = s1_adv && pe_wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bg_mem[s1_addr] <= pe_wr_data;
    end
    if (in_fire) begin
      rd_data_r <= bg_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold    <= THRESHOLD_RST;
      cfg_r.blend_weight <= '0;
      cfg_r.color_mode   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: cfg_r.threshold    <= $signed(cfg_data);
        CFG_BLEND:     cfg_r.blend_weight <= cfg_data[WGT_W-1:0];
        CFG_COLOR:     cfg_r.color_mode   <= cfg_data[0];
        default:       cfg_r              <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (wr_en) begin
        fwd_valid_r <= 1'b1;
      end
      if (s1_adv && s1_has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_action;
      s1_index_r  <= in_pixel_index;
      s1_pix_r    <= {in_chan_c, in_chan_b, in_chan_a};
      s1_inside_r <= in_inside;
    end
    if (wr_en) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= pe_wr_data;
    end
    if (s1_adv && s1_has_result) begin
      out_index_r <= s1_index_r;
      out_fg_r    <= pe_fg;
      out_diff_r  <= pe_diff;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_index           = out_index_r;
  assign out_is_foreground   = out_fg_r;
  assign out_luma_difference = out_diff_r;

endmodule

`default_nettype wire

### src/bgsub_pe.sv
// Per-pixel arithmetic: weighted difference, foreground decision and store update value.
// Depends on bgsub_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgsub_pe (
  input  wire bgsub_pkg::cfg_t                          cfg,
  input  wire logic [bgsub_pkg::ACT_W-1:0]              action,
  input  wire logic                                     in_range,
  input  wire logic [bgsub_pkg::PIX_W-1:0]              pix,
  input  wire logic [bgsub_pkg::PIX_W-1:0]              old,
  output logic                                          wr_en,
  output logic [bgsub_pkg::PIX_W-1:0]                   wr_data,
  output logic                                          is_fg,
  output logic signed [bgsub_pkg::DIFF_W-1:0]           diff
);
  import bgsub_pkg::*;

  logic signed [CH_W:0]     d_ch [3];
  logic [CH_W-1:0]          half_ch [3];
  logic [CH_W-1:0]          blend_ch [3];
  logic [WGT_W-1:0]         w_sat;
  logic [WGT_W-1:0]         w_inv;
  logic [16:0]              mix [3];
  logic signed [DIFF_W-1:0] diff_color;
  logic [PIX_W-1:0]         blended;

  assign w_sat = (cfg.blend_weight > WEIGHT_MAX) ? WEIGHT_MAX : cfg.blend_weight;
  assign w_inv = WEIGHT_MAX - w_sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_ch[k] = $signed({1'b0, pix[k*CH_W +: CH_W]}) - $signed({1'b0, old[k*CH_W +: CH_W]});
      half_ch[k] = {1'b0, pix[k*CH_W+1 +: CH_W-1]} + {1'b0, old[k*CH_W+1 +: CH_W-1]};
      mix[k] = 17'(w_sat * pix[k*CH_W +: CH_W]) + 17'(w_inv * old[k*CH_W +: CH_W]);
      blend_ch[k] = mix[k][15:8];
    end
  end

  assign diff_color = W_RED * DIFF_W'(d_ch[2]) + W_GREEN * DIFF_W'(d_ch[1])
                    + W_BLUE * DIFF_W'(d_ch[0]);
  assign diff  = cfg.color_mode ? diff_color : $signed({d_ch[0], 8'b0});
  assign is_fg = !(diff < cfg.threshold);

  // gray mode keeps the upper two bytes
  assign blended = cfg.color_mode ? {blend_ch[2], blend_ch[1], blend_ch[0]}
                                  : {old[PIX_W-1:CH_W], blend_ch[0]};

  always_comb begin
    wr_en   = 1'b0;
    wr_data = old;
    case (action)
      ACT_LOAD: begin
        wr_en   = in_range;
        wr_data = pix;
      end
      ACT_LEARN: begin
        wr_en   = in_range;
        wr_data = {half_ch[2], half_ch[1], half_ch[0]};
      end
      ACT_SEGMENT: begin
        wr_en   = in_range && !is_fg;
        wr_data = blended;
      end
      default: begin
        wr_en   = 1'b0;
        wr_data = old;
      end
    endcase
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for background_subtraction_pixel: load, learn and segment words
// against a mirror of the background store, over several register settings.
// Depends on bgsub_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import bgsub_pkg::*;

  localparam logic [ACT_W-1:0]     ACT_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam int                   N_DIR       = 22;
  localparam int                   N_PHASE     = 6;
  localparam int                   PHASE_WORDS = 150;
  localparam int                   SETTLE      = 8;
  localparam int                   HOLD_CYCLES = 300;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     fg;
    logic signed [DIFF_W-1:0] diff;
  } mask_word_t;

  typedef struct {
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0]  a;
    logic [CH_W-1:0]  b;
    logic [CH_W-1:0]  c;
    bit               typed;
    bit               fg;
    int               diff;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [ACT_W-1:0] in_action;
  logic [IDX_W-1:0] in_pixel_index;
  logic [CH_W-1:0] in_chan_a;
  logic [CH_W-1:0] in_chan_b;
  logic [CH_W-1:0] in_chan_c;
  logic out_valid;
  logic out_ready;
  logic [IDX_W-1:0] out_index;
  logic out_is_foreground;
  logic signed [DIFF_W-1:0] out_luma_difference;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // expected values typed into the plan travel with the payload
  bit in_typed;
  bit in_typed_fg;
  int in_typed_diff;

  bit calm;
  bit hold_req;
  int errors;
  int words_in;
  int masks_seen;
  int fg_count;
  int cfg_writes;

  // mirror of the block: background store and registers
  logic [PIX_W-1:0] bg_mirror [int unsigned];
  int               thr_m   = THRESHOLD_RST;
  logic [WGT_W-1:0] bw_m    = '0;
  logic             color_m = 1'b1;
  mask_word_t       mask_q [$];

  // stimulus-side view of what each position roughly holds
  logic [PIX_W-1:0] known_bg [int unsigned];
  logic [IDX_W-1:0] spots [$];

  plan_row_t plan [N_DIR];

  background_subtraction_pixel u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_pixel_index      (in_pixel_index),
    .in_chan_a           (in_chan_a),
    .in_chan_b           (in_chan_b),
    .in_chan_c           (in_chan_c),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_index           (out_index),
    .out_is_foreground   (out_is_foreground),
    .out_luma_difference (out_luma_difference),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  // applies one pixel word to the mirror; made is set when a mask word results
  function automatic void subtract_background(
    input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
    input logic [CH_W-1:0] pa, input logic [CH_W-1:0] pb, input logic [CH_W-1:0] pc,
    output bit made, output mask_word_t res);
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] old;
    logic [PIX_W-1:0] upd;
    int da, db, dc, diff, w, o, p, k;
    bit fg;
    px   = {pc, pb, pa};
    old  = bg_mirror.exists(idx) ? bg_mirror[idx] : '0;
    made = 1'b0;
    res  = '0;
    case (act)
      ACT_LOAD: bg_mirror[idx] = px;
      ACT_LEARN: begin
        for (k = 0; k < 3; k++) begin
          o = old[8*k +: 8];
          p = px[8*k +: 8];
          upd[8*k +: 8] = 8'((o >> 1) + (p >> 1));
        end
        bg_mirror[idx] = upd;
      end
      ACT_SEGMENT: begin
        da = int'(px[7:0]) - int'(old[7:0]);
        db = int'(px[15:8]) - int'(old[15:8]);
        dc = int'(px[23:16]) - int'(old[23:16]);
        if (color_m)
          diff = int'(W_RED) * dc + int'(W_GREEN) * db + int'(W_BLUE) * da;
        else
          diff = 256 * da;
        fg = !(diff < thr_m);
        if (!fg) begin
          // weight saturates at 256; gray mode blends the first channel only
          w   = (bw_m > WEIGHT_MAX) ? int'(WEIGHT_MAX) : int'(bw_m);
          upd = old;
          for (k = 0; k < (color_m ? 3 : 1); k++) begin
            o = old[8*k +: 8];
            p = px[8*k +: 8];
            upd[8*k +: 8] = 8'((w * p + (256 - w) * o) >> 8);
          end
          bg_mirror[idx] = upd;
        end
        made     = 1'b1;
        res.idx  = idx;
        res.fg   = fg;
        res.diff = DIFF_W'(diff);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] nudge(input logic [CH_W-1:0] base, input int d);
    int v;
    v = int'(base) + d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CH_W'(v);
  endfunction

  // input side, register side and output side sampled in one process
  always @(posedge clk) begin : scoreboard
    bit made;
    mask_word_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          CFG_THRESHOLD: thr_m = $signed(cfg_data);
          CFG_BLEND:     bw_m = cfg_data[WGT_W-1:0];
          CFG_COLOR:     color_m = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        words_in++;
        subtract_background(in_action, in_pixel_index, in_chan_a, in_chan_b, in_chan_c,
                            made, want);
        if (made) begin
          if (in_typed) begin
            want.fg   = in_typed_fg;
            want.diff = DIFF_W'(in_typed_diff);
          end
          mask_q.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        masks_seen++;
        if (out_is_foreground === 1'b1) fg_count++;
        if (mask_q.size() == 0) begin
          $error("mask word with nothing pending, out_index %0d", out_index);
          errors++;
        end else begin
          want = mask_q.pop_front();
          if (out_index !== want.idx) begin
            $error("out_index: expected %0d, got %0d", want.idx, out_index);
            errors++;
          end
          if (out_is_foreground !== want.fg) begin
            $error("is_foreground: expected %0d, got %0d", want.fg, out_is_foreground);
            errors++;
          end
          if (out_luma_difference !== want.diff) begin
            $error("luma_difference: expected %0d, got %0d", want.diff,
                   out_luma_difference);
            errors++;
          end
        end
      end
    end
  end

  // result side: random stalls, a calm stretch, and one long hold-off on request
  initial begin : rx_side
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic offer_word(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                            input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                            input logic [CH_W-1:0] c, input bit typed, input bit fg,
                            input int diff);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_pixel_index <= idx;
    in_chan_a      <= a;
    in_chan_b      <= b;
    in_chan_c      <= c;
    in_typed       <= typed;
    in_typed_fg    <= fg;
    in_typed_diff  <= diff;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait for every pending mask word, then for the pipeline tail
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (mask_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] bw,
                              input logic [CFG_DATA_W-1:0] col);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_BLEND, bw);
    write_reg(CFG_COLOR, col);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly segments of seeded positions, near or far from their background
  task automatic pick_word(output logic [ACT_W-1:0] act, output logic [IDX_W-1:0] idx,
                           output logic [CH_W-1:0] a, output logic [CH_W-1:0] b,
                           output logic [CH_W-1:0] c);
    int r, d;
    logic [PIX_W-1:0] bg;
    r   = $urandom_range(99);
    idx = spots[$urandom_range(spots.size() - 1)];
    a   = $urandom_range(255);
    b   = $urandom_range(255);
    c   = $urandom_range(255);
    if (r < 5) begin
      idx = $urandom_range(0, (1 << IDX_W) - 1);
      spots.push_back(idx);
    end
    bg = known_bg.exists(idx) ? known_bg[idx] : '0;
    if (r < 20 || !known_bg.exists(idx)) begin
      act = ACT_LOAD;
      known_bg[idx] = {c, b, a};
    end else if (r < 32) begin
      act = ACT_LEARN;
      known_bg[idx] = {8'((bg[23:16] >> 1) + (c >> 1)), 8'((bg[15:8] >> 1) + (b >> 1)),
                       8'((bg[7:0] >> 1) + (a >> 1))};
    end else if (r < 38) begin
      act = ACT_SPARE;
    end else begin
      act = ACT_SEGMENT;
      if (r < 58) begin
        // same step on all channels lands on multiples of 256
        d = $urandom_range(6) - 3;
        a = nudge(bg[7:0], d);
        b = nudge(bg[15:8], d);
        c = nudge(bg[23:16], d);
      end else if (r < 78) begin
        a = nudge(bg[7:0], $urandom_range(24) - 12);
        b = nudge(bg[15:8], $urandom_range(24) - 12);
        c = nudge(bg[23:16], $urandom_range(24) - 12);
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] ph_thr [N_PHASE];
    logic [CFG_DATA_W-1:0] ph_bw  [N_PHASE];
    logic [CFG_DATA_W-1:0] ph_col [N_PHASE];
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0] a, b, c;
    int n;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_LOAD;
    in_pixel_index = '0;
    in_chan_a      = '0;
    in_chan_b      = '0;
    in_chan_c      = '0;
    in_typed       = 1'b0;
    in_typed_fg    = 1'b0;
    in_typed_diff  = 0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_THRESHOLD;
    cfg_data       = '0;
    calm           = 1'b0;
    hold_req       = 1'b0;

    // reset settings: threshold 2560, weight 0 (store kept), colour mode
    plan = '{
      '{ACT_LOAD,    19'h00000, 8'h00, 8'h00, 8'h00, 0, 0, 0},
      '{ACT_LOAD,    19'h7FFFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0},
      '{ACT_SEGMENT, 19'h00000, 8'hFF, 8'hFF, 8'hFF, 1, 1, 65280},
      '{ACT_SEGMENT, 19'h7FFFF, 8'h00, 8'h00, 8'h00, 1, 0, -65280},
      '{ACT_SEGMENT, 19'h7FFFF, 8'hFF, 8'hFF, 8'hFF, 1, 0, 0},
      '{ACT_SEGMENT, 19'h00000, 8'h00, 8'h00, 8'h00, 1, 0, 0},
      '{ACT_LEARN,   19'h00000, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0},
      '{ACT_SEGMENT, 19'h00000, 8'h7F, 8'h7F, 8'h7F, 1, 0, 0},
      '{ACT_LEARN,   19'h7FFFF, 8'h00, 8'h00, 8'h00, 0, 0, 0},
      '{ACT_SEGMENT, 19'h7FFFF, 8'h89, 8'h7F, 8'h7F, 0, 0, 0},
      '{ACT_LOAD,    19'h2AAAA, 8'h55, 8'hAA, 8'h55, 0, 0, 0},
      '{ACT_LOAD,    19'h55555, 8'hAA, 8'h55, 8'hAA, 0, 0, 0},
      '{ACT_SEGMENT, 19'h2AAAA, 8'hAA, 8'h55, 8'hAA, 0, 0, 0},
      '{ACT_SEGMENT, 19'h55555, 8'h55, 8'hAA, 8'h55, 0, 0, 0},
      '{ACT_SPARE,   19'h00000, 8'hFF, 8'h00, 8'hFF, 0, 0, 0},
      '{ACT_LOAD,    19'h00006, 8'h00, 8'h00, 8'h00, 0, 0, 0},
      '{ACT_SEGMENT, 19'h00006, 8'h00, 8'h01, 8'h00, 1, 0, 150},
      '{ACT_SEGMENT, 19'h00006, 8'h00, 8'h00, 8'h01, 1, 0, 77},
      '{ACT_SEGMENT, 19'h00006, 8'h01, 8'h00, 8'h00, 1, 0, 29},
      '{ACT_SEGMENT, 19'h00006, 8'h00, 8'd18, 8'h00, 1, 1, 2700},
      '{ACT_LEARN,   19'h00006, 8'h01, 8'h01, 8'h01, 0, 0, 0},
      '{ACT_SEGMENT, 19'h00006, 8'h00, 8'h00, 8'h00, 1, 0, 0}
    };

    ph_thr[0] = 17'h00000;  ph_bw[0] = 17'd128;    ph_col[0] = 17'h00001;
    ph_thr[1] = 17'h10000;  ph_bw[1] = 17'h1FFFF;  ph_col[1] = 17'h1FFFF;
    ph_thr[2] = 17'h0FFFF;  ph_bw[2] = 17'd256;    ph_col[2] = 17'h1FFFE;
    ph_thr[3] = 17'd2560;   ph_bw[3] = $urandom_range(256); ph_col[3] = 17'h00000;
    ph_thr[4] = 17'd256;    ph_bw[4] = 17'd1;      ph_col[4] = 17'h00001;
    ph_thr[5] = $urandom_range(17'h1FFFF);
    ph_bw[5]  = $urandom_range(511);
    ph_col[5] = $urandom_range(1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < N_DIR; n++) begin
      offer_word(plan[n].act, plan[n].idx, plan[n].a, plan[n].b, plan[n].c,
                 plan[n].typed, plan[n].fg, plan[n].diff);
      if (plan[n].act == ACT_LOAD) known_bg[plan[n].idx] = {plan[n].c, plan[n].b, plan[n].a};
    end
    settle();

    // the plan leaves its positions in a state the stimulus view does not track
    known_bg.delete();
    spots.push_back('0);
    spots.push_back('1);
    repeat (30) spots.push_back($urandom_range(0, (1 << IDX_W) - 1));

    for (int ph = 0; ph < N_PHASE; ph++) begin
      if (ph == 4) write_reg(CFG_SPARE, 17'h1ABCD);
      program_regs(ph_thr[ph], ph_bw[ph], ph_col[ph]);
      if (ph == 1) hold_req = 1'b1;
      for (n = 0; n < PHASE_WORDS; n++) begin
        calm = (ph == 3 && n < 100);
        if (ph == 0 && n == PHASE_WORDS / 2) settle();
        pick_word(act, idx, a, b, c);
        offer_word(act, idx, a, b, c, 0, 0, 0);
      end
      calm = 1'b0;
      settle();
    end

    in_valid <= 1'b0;
    for (n = 0; n < 5000 && mask_q.size() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mask_q.size() != 0) begin
      $error("%0d mask words never arrived", mask_q.size());
      errors++;
    end

    $display("run: %0d pixel words over %0d register settings, %0d register writes",
             words_in, N_PHASE + 1, cfg_writes);
    $display("run: %0d mask words compared, %0d foreground, %0d mismatches",
             masks_seen, fg_count, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### background_subtraction_pixel.f
src/bgsub_pkg.sv
src/bgsub_pe.sv
src/background_subtraction_pixel.sv
tb/tb_top.sv
